[src/iptsm_pkg.sv]
// Shared constants and types for the IPv4 TCP payload signature match unit.
`timescale 1ns / 1ps

package iptsm_pkg;

    // Signature length in payload bytes and the width of the compare counter
    localparam int SIG_BYTES = 11;
    localparam int SIG_CNT_W = $clog2(SIG_BYTES + 1);
    localparam int SIG_PAD_W = (1 << SIG_CNT_W) * 8;

    // Register widths and reset values
    localparam int LINK_W     = 8;
    localparam int SIG_LOW_W  = 64;
    localparam int SIG_HIGH_W = 24;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 2;

    localparam logic [LINK_W-1:0]     LINK_HDR_RESET = 8'd14;
    localparam logic [SIG_LOW_W-1:0]  SIG_LOW_RESET  = 64'h10;
    localparam logic [SIG_HIGH_W-1:0] SIG_HIGH_RESET = 24'h1DD;

    // Register indexes on the configuration port
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_LINK_HDR = 2'd0,
        REG_SIG_LOW  = 2'd1,
        REG_SIG_HIGH = 2'd2
    } cfg_reg_t;

    // Header layout
    localparam logic [3:0] IP_VERSION_4   = 4'd4;
    localparam int         TOT_LEN_HI_OFS = 2;
    localparam int         TOT_LEN_LO_OFS = 3;
    localparam int         TCP_DOFF_OFS   = 12;
    localparam int         TCP_MIN_HDR    = 16;

    // Field widths
    localparam int POS_W    = 16;
    localparam int HLEN_W   = 6;
    localparam int TOTAL_W  = 16;
    localparam int OFFSET_W = 9;
    localparam int START_W  = 10;
    localparam int M_DATA_W = 32;

    // One result item
    typedef struct packed {
        logic                is_ipv4;
        logic                signature_hit;
        logic [OFFSET_W-1:0] payload_offset;
        logic [TOTAL_W-1:0]  payload_length;
        logic                length_error;
    } result_t;

endpackage

[src/ipv4_tcp_payload_signature_match_unit.sv]
// IPv4 TCP payload prefix signature matcher: header parse, payload compare, result.
//
//  channel | dir | handshake            | content
//  --------+-----+----------------------+-----------------------------------------
//  s_      | in  | s_tvalid / s_tready  | one frame byte, s_tlast on the last byte
//  m_      | out | m_tvalid / m_tready  | one result per frame, after its last byte
//  cfg_    | in  | cfg_wr_en            | link header length and signature bytes
//
// One byte per cycle unless a last byte waits on a held result: while a byte sits in the
// input register, the header capture, payload compare and result logic update the frame state.
// A result is loaded into the output register when the last byte leaves the input register.
// aresetn (synchronous) clears the frame state and restores the register defaults.
// A result left waiting on m_tready stalls only the processing of the next last byte.
`timescale 1ns / 1ps

module ipv4_tcp_payload_signature_match_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input channel
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] frame_byte
    input  logic                               s_tlast,   // frame_end
    // result channel
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] is_ipv4, [1] signature_hit, [10:2] payload_offset,
    // [26:11] payload_length, [27] length_error, [31:28] zero
    output logic [iptsm_pkg::M_DATA_W-1:0]     m_tdata,
    // configuration
    input  logic                               cfg_wr_en,
    input  logic [iptsm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [iptsm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int PW = iptsm_pkg::POS_W;
    localparam int HW = iptsm_pkg::HLEN_W;
    localparam int TW = iptsm_pkg::TOTAL_W;
    localparam int SW = iptsm_pkg::START_W;
    localparam int CW = iptsm_pkg::SIG_CNT_W;

    // configuration registers
    logic [iptsm_pkg::LINK_W-1:0]     link_reg;
    logic [iptsm_pkg::SIG_LOW_W-1:0]  sig_low_reg;
    logic [iptsm_pkg::SIG_HIGH_W-1:0] sig_high_reg;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // frame state
    logic [PW-1:0] pos_reg,  pos_next;
    logic          ver_reg,  ver_next;
    logic [HW-1:0] ihl_reg,  ihl_next;
    logic [TW-1:0] tot_reg,  tot_next;
    logic [HW-1:0] thl_reg,  thl_next;
    logic          match_reg, match_next;
    logic [CW-1:0] cmp_reg,  cmp_next;

    // result register
    logic                  out_valid_reg;
    iptsm_pkg::result_t    out_reg, out_next;

    logic                  advance;
    logic [SW-1:0]         base;
    logic [SW-1:0]         tcp_pos;
    logic [SW-1:0]         start;
    logic [HW:0]           hdr;
    logic                  err;
    logic [TW-1:0]         len;
    logic                  cmp_en;
    logic [iptsm_pkg::SIG_PAD_W-1:0] sig_pad;
    logic [7:0]            sig_byte;

    // A byte without the end mark always moves on; a last byte waits for a free slot
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign base    = SW'(link_reg);
    assign sig_pad = iptsm_pkg::SIG_PAD_W'({sig_high_reg, sig_low_reg});
    assign sig_byte = sig_pad[{cmp_reg, 3'b000} +: 8];

    always_comb begin
        ver_next = ver_reg;
        ihl_next = ihl_reg;
        tot_next = tot_reg;
        thl_next = thl_reg;
        match_next = match_reg;
        cmp_next = cmp_reg;

        if (pos_reg == PW'(base)) begin
            ver_next = (in_byte_reg[7:4] == iptsm_pkg::IP_VERSION_4);
            ihl_next = {in_byte_reg[3:0], 2'b00};
        end
        if (pos_reg == PW'(base + SW'(iptsm_pkg::TOT_LEN_HI_OFS))) begin
            tot_next[15:8] = in_byte_reg;
        end
        if (pos_reg == PW'(base + SW'(iptsm_pkg::TOT_LEN_LO_OFS))) begin
            tot_next[7:0] = in_byte_reg;
        end
        tcp_pos = base + SW'(ihl_next) + SW'(iptsm_pkg::TCP_DOFF_OFS);
        if (pos_reg == PW'(tcp_pos)) begin
            thl_next = {in_byte_reg[7:4], 2'b00};
        end

        start  = base + SW'(ihl_next) + SW'(thl_next);
        cmp_en = (thl_next >= HW'(iptsm_pkg::TCP_MIN_HDR)) && (pos_reg >= PW'(start)) &&
                 (cmp_reg < CW'(iptsm_pkg::SIG_BYTES));
        if (cmp_en) begin
            if (in_byte_reg != sig_byte) begin
                match_next = 1'b0;
            end
            cmp_next = cmp_reg + CW'(1);
        end

        // Saturate the payload length when the headers overrun the total length
        hdr = (HW + 1)'(ihl_next) + (HW + 1)'(thl_next);
        err = TW'(hdr) > tot_next;
        len = err ? '0 : tot_next - TW'(hdr);

        out_next = '0;
        if (ver_next) begin
            out_next.is_ipv4        = 1'b1;
            out_next.signature_hit  = !err && (len >= TW'(iptsm_pkg::SIG_BYTES)) &&
                                      (thl_next >= HW'(iptsm_pkg::TCP_MIN_HDR)) &&
                                      (cmp_next == CW'(iptsm_pkg::SIG_BYTES)) && match_next;
            out_next.payload_offset = start[iptsm_pkg::OFFSET_W-1:0];
            out_next.payload_length = len;
            out_next.length_error   = err;
        end

        pos_next = (pos_reg == '1) ? pos_reg : pos_reg + PW'(1);
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_reg     <= iptsm_pkg::LINK_HDR_RESET;
            sig_low_reg  <= iptsm_pkg::SIG_LOW_RESET;
            sig_high_reg <= iptsm_pkg::SIG_HIGH_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                iptsm_pkg::REG_LINK_HDR: link_reg <= cfg_wdata[iptsm_pkg::LINK_W-1:0];
                iptsm_pkg::REG_SIG_LOW:  sig_low_reg <= cfg_wdata[iptsm_pkg::SIG_LOW_W-1:0];
                iptsm_pkg::REG_SIG_HIGH: sig_high_reg <= cfg_wdata[iptsm_pkg::SIG_HIGH_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // frame state: clear after the last byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            ver_reg   <= 1'b0;
            ihl_reg   <= '0;
            tot_reg   <= '0;
            thl_reg   <= '0;
            match_reg <= 1'b1;
            cmp_reg   <= '0;
        end else if (advance) begin
            if (in_last_reg) begin
                pos_reg   <= '0;
                ver_reg   <= 1'b0;
                ihl_reg   <= '0;
                tot_reg   <= '0;
                thl_reg   <= '0;
                match_reg <= 1'b1;
                cmp_reg   <= '0;
            end else begin
                pos_reg   <= pos_next;
                ver_reg   <= ver_next;
                ihl_reg   <= ihl_next;
                tot_reg   <= tot_next;
                thl_reg   <= thl_next;
                match_reg <= match_next;
                cmp_reg   <= cmp_next;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = iptsm_pkg::M_DATA_W'({out_reg.length_error, out_reg.payload_length,
                                            out_reg.payload_offset, out_reg.signature_hit,
                                            out_reg.is_ipv4});

    // A non-IPv4 frame reports all fields as zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_reg.is_ipv4 |->
            !out_reg.signature_hit && out_reg.payload_offset == '0 &&
            out_reg.payload_length == '0 && !out_reg.length_error)
        else $error("non-IPv4 result carries non-zero fields");

    // A hit never coexists with a length error
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.signature_hit |-> out_reg.is_ipv4 && !out_reg.length_error)
        else $error("signature hit reported with a length error");

    // The compare counter never passes the signature length
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_reg <= CW'(iptsm_pkg::SIG_BYTES))
        else $error("compare counter overran the signature");

    // After a last byte the frame state starts over and a result is pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_last_reg |=> pos_reg == '0 && cmp_reg == '0 && match_reg && out_valid_reg)
        else $error("frame state not cleared after the last byte");

endmodule

[bench/tb_top.sv]
// Self-checking bench for the IPv4 TCP payload signature match unit.
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT     = 1000000;
    localparam int RANDOM_BYTES    = 1000;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int DRAIN_CYCLES    = 8;
    localparam int POS_MAX         = 65535;
    localparam logic [iptsm_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

    typedef enum int { SIG_EXACT, SIG_FLIP, SIG_RAND } sig_mode_t;
    typedef logic [7:0] frame_q_t[$];

    typedef struct {
        int                 ver;
        int                 ihl_n;
        int                 tot;
        int                 doff_n;
        sig_mode_t          mode;
        int                 extra;
        int                 cut;
        bit                 typed;
        iptsm_pkg::result_t want;
    } frame_row_t;

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [7:0]                       s_tdata   = '0;
    logic                             s_tlast   = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [iptsm_pkg::M_DATA_W-1:0]   m_tdata;
    logic                             cfg_wr_en = 1'b0;
    logic [iptsm_pkg::CFG_ADDR_W-1:0] cfg_addr  = iptsm_pkg::REG_LINK_HDR;
    logic [iptsm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // register copy and per-frame parse state of the predictor
    logic [iptsm_pkg::LINK_W-1:0]     link_len;
    logic [iptsm_pkg::SIG_LOW_W-1:0]  sig_low;
    logic [iptsm_pkg::SIG_HIGH_W-1:0] sig_high;
    logic [iptsm_pkg::POS_W-1:0]      pos;
    logic                             ver_ok;
    logic [iptsm_pkg::HLEN_W-1:0]     ihl_bytes;
    logic [iptsm_pkg::TOTAL_W-1:0]    tot_len;
    logic [iptsm_pkg::HLEN_W-1:0]     thl_bytes;
    logic                             sig_ok;
    logic [iptsm_pkg::SIG_CNT_W-1:0]  cmp_cnt;

    iptsm_pkg::result_t pending_results[$];
    frame_row_t         dir_tab[$];
    iptsm_pkg::result_t want;
    int         error_count  = 0;
    int         results_seen = 0;
    int         bytes_sent   = 0;
    int         cycle_count  = 0;
    int         hold_cycles  = 0;
    int         hold_at      = -1;
    bit         sink_burst   = 1'b0;

    ipv4_tcp_payload_signature_match_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic void clear_parse();
        pos       = '0;
        ver_ok    = 1'b0;
        ihl_bytes = '0;
        tot_len   = '0;
        thl_bytes = '0;
        sig_ok    = 1'b1;
        cmp_cnt   = '0;
    endfunction

    // Advance the parse by one frame byte; on the last byte yield the frame result.
    task automatic advance_parser(input logic [7:0] b, input logic last,
                                  output bit done, output iptsm_pkg::result_t r);
        int base;
        int start;
        int hdr;
        logic [iptsm_pkg::SIG_LOW_W+iptsm_pkg::SIG_HIGH_W-1:0] sig;
        base = int'(link_len);
        sig  = {sig_high, sig_low};
        done = 1'b0;
        r    = '0;
        if (pos == base) begin
            ver_ok    = (b[7:4] == iptsm_pkg::IP_VERSION_4);
            ihl_bytes = {b[3:0], 2'b00};
        end
        if (pos == base + iptsm_pkg::TOT_LEN_HI_OFS) tot_len[15:8] = b;
        if (pos == base + iptsm_pkg::TOT_LEN_LO_OFS) tot_len[7:0] = b;
        if (pos == base + ihl_bytes + iptsm_pkg::TCP_DOFF_OFS) thl_bytes = {b[7:4], 2'b00};
        start = base + ihl_bytes + thl_bytes;
        if (thl_bytes >= iptsm_pkg::TCP_MIN_HDR && pos >= start &&
            cmp_cnt < iptsm_pkg::SIG_BYTES) begin
            if (b != sig[8*cmp_cnt +: 8]) sig_ok = 1'b0;
            cmp_cnt++;
        end
        if (!last) begin
            // saturate rather than wrap back onto the header offsets
            if (pos < POS_MAX) pos++;
        end else begin
            done = 1'b1;
            hdr  = ihl_bytes + thl_bytes;
            if (ver_ok) begin
                r.is_ipv4        = 1'b1;
                r.payload_offset = start[iptsm_pkg::OFFSET_W-1:0];
                if (hdr > tot_len) r.length_error = 1'b1;
                else r.payload_length = iptsm_pkg::TOTAL_W'(int'(tot_len) - hdr);
                r.signature_hit = !r.length_error &&
                                  r.payload_length >= iptsm_pkg::SIG_BYTES &&
                                  thl_bytes >= iptsm_pkg::TCP_MIN_HDR &&
                                  cmp_cnt == iptsm_pkg::SIG_BYTES && sig_ok;
            end
            clear_parse();
        end
    endtask

    task automatic write_reg(input logic [iptsm_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [iptsm_pkg::CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        case (addr)
            iptsm_pkg::REG_LINK_HDR: link_len = data[iptsm_pkg::LINK_W-1:0];
            iptsm_pkg::REG_SIG_LOW:  sig_low  = data[iptsm_pkg::SIG_LOW_W-1:0];
            iptsm_pkg::REG_SIG_HIGH: sig_high = data[iptsm_pkg::SIG_HIGH_W-1:0];
            default: ;
        endcase
    endtask

    // Drain the block, then load a new link length and signature.
    task automatic set_phase(input logic [iptsm_pkg::LINK_W-1:0] link,
                             input logic [iptsm_pkg::SIG_LOW_W-1:0] lo,
                             input logic [iptsm_pkg::SIG_HIGH_W-1:0] hi);
        logic [iptsm_pkg::CFG_DATA_W-1:0] junk;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        junk = {$urandom, $urandom};
        write_reg(iptsm_pkg::REG_LINK_HDR,
                  {junk[iptsm_pkg::CFG_DATA_W-1:iptsm_pkg::LINK_W], link});
        write_reg(iptsm_pkg::REG_SIG_LOW, lo);
        write_reg(iptsm_pkg::REG_SIG_HIGH,
                  {junk[iptsm_pkg::CFG_DATA_W-1:iptsm_pkg::SIG_HIGH_W], hi});
        write_reg(REG_UNUSED, junk);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last, input bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 4);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_frame(input frame_q_t q, input bit typed,
                              input iptsm_pkg::result_t typed_r);
        bit                 burst;
        bit                 done;
        iptsm_pkg::result_t r;
        burst = (q.size() > 1000) || ($urandom_range(0, 3) == 0);
        foreach (q[i]) begin
            send_byte(q[i], i == q.size() - 1, burst);
            advance_parser(q[i], i == q.size() - 1, done, r);
            if (done) pending_results.push_back(typed ? typed_r : r);
        end
    endtask

    // Lay out link header, IPv4 header fields, TCP data offset and payload on random filler.
    task automatic build_frame(input int ver, input int ihl_n, input int tot, input int doff_n,
                               input sig_mode_t mode, input int extra, input int cut,
                               output frame_q_t q);
        int base;
        int ip_len;
        int start;
        int n;
        int p;
        logic [iptsm_pkg::SIG_LOW_W+iptsm_pkg::SIG_HIGH_W-1:0] sig;
        base   = int'(link_len);
        ip_len = ihl_n * 4;
        start  = base + ip_len + doff_n * 4;
        sig    = {sig_high, sig_low};
        n      = start + iptsm_pkg::SIG_BYTES + extra;
        if (n < base + ip_len + iptsm_pkg::TCP_DOFF_OFS + 1)
            n = base + ip_len + iptsm_pkg::TCP_DOFF_OFS + 1;
        if (cut > 0) n = cut;
        q = {};
        for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(0, 255)));
        if (base < n) q[base] = {ver[3:0], ihl_n[3:0]};
        if (base + iptsm_pkg::TOT_LEN_HI_OFS < n) q[base + iptsm_pkg::TOT_LEN_HI_OFS] = tot[15:8];
        if (base + iptsm_pkg::TOT_LEN_LO_OFS < n) q[base + iptsm_pkg::TOT_LEN_LO_OFS] = tot[7:0];
        p = base + ip_len + iptsm_pkg::TCP_DOFF_OFS;
        if (p < n) q[p] = {doff_n[3:0], q[p][3:0]};
        if (doff_n * 4 >= iptsm_pkg::TCP_MIN_HDR && mode != SIG_RAND) begin
            for (int k = 0; k < iptsm_pkg::SIG_BYTES; k++) begin
                if (start + k < n) q[start + k] = sig[8*k +: 8];
            end
            if (mode == SIG_FLIP) begin
                p = start + $urandom_range(0, iptsm_pkg::SIG_BYTES - 1);
                if (p < n) q[p] = q[p] ^ 8'($urandom_range(1, 255));
            end
        end
    endtask

    task automatic add_row(input int ver, input int ihl_n, input int tot, input int doff_n,
                           input sig_mode_t mode, input int extra, input int cut,
                           input bit typed, input bit e_ip, input bit e_hit,
                           input int e_ofs, input int e_len, input bit e_err);
        frame_row_t r;
        r.ver    = ver;
        r.ihl_n  = ihl_n;
        r.tot    = tot;
        r.doff_n = doff_n;
        r.mode   = mode;
        r.extra  = extra;
        r.cut    = cut;
        r.typed  = typed;
        r.want   = '0;
        r.want.is_ipv4        = e_ip;
        r.want.signature_hit  = e_hit;
        r.want.payload_offset = e_ofs[iptsm_pkg::OFFSET_W-1:0];
        r.want.payload_length = e_len[iptsm_pkg::TOTAL_W-1:0];
        r.want.length_error   = e_err;
        dir_tab.push_back(r);
    endtask

    // Mostly well-formed IPv4/TCP frames, with broken lengths, cut frames and raw noise.
    task automatic send_random_frame();
        int                 ver;
        int                 ihl_n;
        int                 doff_n;
        int                 extra;
        int                 hdr;
        int                 tot;
        int                 cut;
        int                 pick;
        sig_mode_t          mode;
        frame_q_t           q;
        iptsm_pkg::result_t none;
        none = '0;
        if ($urandom_range(0, 19) == 0) begin
            q = {};
            repeat ($urandom_range(1, 20)) q.push_back(8'($urandom_range(0, 255)));
        end else begin
            ver   = ($urandom_range(0, 9) != 0) ? 4 : $urandom_range(0, 15);
            ihl_n = ($urandom_range(0, 9) < 7) ? 5 : $urandom_range(0, 15);
            pick  = $urandom_range(0, 19);
            if (pick < 12) doff_n = 5;
            else if (pick < 17) doff_n = $urandom_range(4, 15);
            else doff_n = $urandom_range(0, 3);
            extra = $urandom_range(0, 8);
            hdr   = 4 * (ihl_n + doff_n);
            pick  = $urandom_range(0, 19);
            if (pick < 15) tot = hdr + iptsm_pkg::SIG_BYTES + extra;
            else if (pick < 17) tot = $urandom_range(0, 65535);
            else if (pick < 19) tot = (hdr > 0) ? $urandom_range(0, hdr - 1) : 0;
            else tot = hdr + $urandom_range(0, iptsm_pkg::SIG_BYTES - 1);
            pick = $urandom_range(0, 19);
            if (pick < 13) mode = SIG_EXACT;
            else if (pick < 18) mode = SIG_FLIP;
            else mode = SIG_RAND;
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, int'(link_len) + 140) : 0;
            build_frame(ver, ihl_n, tot, doff_n, mode, extra, cut, q);
        end
        send_frame(q, 1'b0, none);
    endtask

    function automatic void check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with no frame outstanding: m_tdata %h", m_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("is_ipv4", want.is_ipv4, m_tdata[0]);
                check_field("signature_hit", want.signature_hit, m_tdata[1]);
                check_field("payload_offset", want.payload_offset, m_tdata[10:2]);
                check_field("payload_length", want.payload_length, m_tdata[26:11]);
                check_field("length_error", want.length_error, m_tdata[27]);
                check_field("m_tdata padding", 0, m_tdata[31:28]);
            end
            results_seen++;
            if (results_seen == hold_at) hold_cycles = HOLD_OFF_CYCLES;
            else hold_cycles = sink_burst ? 0 : $urandom_range(0, 4);
            if ($urandom_range(0, 7) == 0) sink_burst = !sink_burst;
        end
    end

    // Result sink: hold m_tready low while the stall count runs down.
    initial begin : result_sink
        forever begin
            @(negedge aclk);
            if (!aresetn || hold_cycles > 0) begin
                m_tready <= 1'b0;
                if (hold_cycles > 0) hold_cycles--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        frame_q_t                         q;
        int                               ph;
        logic [iptsm_pkg::LINK_W-1:0]     link;
        logic [iptsm_pkg::SIG_LOW_W-1:0]  lo;
        logic [iptsm_pkg::SIG_HIGH_W-1:0] hi;
        link_len = iptsm_pkg::LINK_HDR_RESET;
        sig_low  = iptsm_pkg::SIG_LOW_RESET;
        sig_high = iptsm_pkg::SIG_HIGH_RESET;
        clear_parse();
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // directed frames under the reset register values
        add_row(6, 5, 51, 5, SIG_EXACT, 0, 0, 1, 0, 0, 0, 0, 0);
        add_row(4, 5, 51, 5, SIG_EXACT, 0, 0, 1, 1, 1, 54, 11, 0);
        add_row(4, 5, 51, 5, SIG_FLIP, 0, 0, 1, 1, 0, 54, 11, 0);
        add_row(4, 5, 30, 5, SIG_EXACT, 0, 0, 1, 1, 0, 54, 0, 1);
        add_row(4, 5, 100, 3, SIG_EXACT, 0, 0, 1, 1, 0, 46, 68, 0);
        add_row(4, 5, 60, 0, SIG_RAND, 0, 0, 1, 1, 0, 34, 40, 0);
        add_row(4, 5, 51, 5, SIG_EXACT, 0, 59, 1, 1, 0, 54, 11, 0);
        add_row(4, 5, 51, 5, SIG_EXACT, 0, 15, 0, 0, 0, 0, 0, 0);
        add_row(4, 5, 51, 5, SIG_EXACT, 0, 1, 1, 0, 0, 0, 0, 0);
        add_row(4, 15, 65535, 15, SIG_EXACT, 0, 0, 1, 1, 1, 134, 65415, 0);
        add_row(4, 0, 31, 5, SIG_EXACT, 3, 0, 0, 0, 0, 0, 0, 0);
        add_row(4, 5, 40, 5, SIG_EXACT, 0, 0, 1, 1, 0, 54, 0, 0);
        add_row(4, 5, 50, 5, SIG_EXACT, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(15, 5, 51, 5, SIG_EXACT, 0, 0, 1, 0, 0, 0, 0, 0);
        add_row(0, 0, 0, 0, SIG_RAND, 0, 0, 1, 0, 0, 0, 0, 0);
        add_row(4, 6, 59, 4, SIG_EXACT, 2, 0, 0, 0, 0, 0, 0, 0);
        add_row(4, 5, 51, 5, SIG_EXACT, 0, 0, 1, 1, 1, 54, 11, 0);

        // long receiver hold-off early in the first random phase
        hold_at = dir_tab.size() + 2;
        foreach (dir_tab[i]) begin
            build_frame(dir_tab[i].ver, dir_tab[i].ihl_n, dir_tab[i].tot, dir_tab[i].doff_n,
                        dir_tab[i].mode, dir_tab[i].extra, dir_tab[i].cut, q);
            send_frame(q, dir_tab[i].typed, dir_tab[i].want);
        end

        bytes_sent = 0;
        for (ph = 0; ph < 4 || bytes_sent < RANDOM_BYTES; ph++) begin
            case (ph)
                0: begin
                    link = '0;
                    lo   = '0;
                    hi   = '0;
                end
                1: begin
                    link = '1;
                    lo   = '1;
                    hi   = '1;
                end
                2: begin
                    link = iptsm_pkg::LINK_HDR_RESET;
                    lo   = {$urandom, $urandom};
                    hi   = iptsm_pkg::SIG_HIGH_W'($urandom);
                end
                default: begin
                    link = ($urandom_range(0, 9) < 7)
                         ? iptsm_pkg::LINK_W'($urandom_range(0, 40))
                         : iptsm_pkg::LINK_W'($urandom_range(0, 255));
                    lo   = {$urandom, $urandom};
                    hi   = iptsm_pkg::SIG_HIGH_W'($urandom);
                end
            endcase
            set_phase(link, lo, hi);
            repeat ((link > 100) ? 3 : 6) send_random_frame();
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
